// ----- hw/rtl/vct_pkg.sv -----
`timescale 1ns / 1ps

package vct_pkg;

	localparam int ValueW    = 16;
	localparam int IntervalW = 16;
	localparam int CmdW      = 2;

	localparam logic [CmdW-1:0] CMD_TICK    = 2'd0;
	localparam logic [CmdW-1:0] CMD_CHANGE  = 2'd1;
	localparam logic [CmdW-1:0] CMD_PRESS   = 2'd2;
	localparam logic [CmdW-1:0] CMD_RELEASE = 2'd3;

	localparam logic [IntervalW-1:0] IntervalReset = 16'd100;
	localparam logic [IntervalW-1:0] TicksMax      = '1;

	typedef struct packed {
		logic                     held;
		logic signed [ValueW-1:0] new_value;
		logic [CmdW-1:0]          command;
	} item_t;

	typedef struct packed {
		logic                     forwarded;
		logic signed [ValueW-1:0] out_value;
	} result_t;

	typedef struct packed {
		logic clock_valid;
		logic pending;
		logic armed;
		logic left_zero;
	} status_t;

endpackage

// ----- hw/rtl/vct_in_stage.sv -----
`timescale 1ns / 1ps

module vct_in_stage
	import vct_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  drain,
	input  item_t item_in,
	output logic  valid_s1,
	output item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ----- hw/rtl/vct_core.sv -----
`timescale 1ns / 1ps

module vct_core
	import vct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IntervalW-1:0] cfg_wdata,
	input  logic                 fire,
	input  item_t                item_s1,
	output result_t              res_s2,
	output status_t              status
);

	logic [IntervalW-1:0] min_interval_q;
	logic [ValueW-1:0]    last_sent_q, last_sent_d;
	logic                 clock_valid_q, clock_valid_d;
	logic [IntervalW-1:0] elapsed_q, elapsed_d;
	logic [ValueW-1:0]    pending_value_q;
	logic                 pending_we;
	logic                 pending_q, pending_d;
	logic                 armed_q, armed_d;
	logic [IntervalW-1:0] left_q, left_d;
	logic                 try_fwd;
	logic [ValueW-1:0]    fwd_value;
	result_t              res_d;

	always_comb begin
		last_sent_d   = last_sent_q;
		clock_valid_d = clock_valid_q;
		elapsed_d     = elapsed_q;
		pending_d     = pending_q;
		armed_d       = armed_q;
		left_d        = left_q;
		pending_we    = 1'b0;
		try_fwd       = 1'b0;
		fwd_value     = item_s1.new_value;

		case (item_s1.command)
			CMD_TICK: begin
				if (elapsed_q != TicksMax) begin
					elapsed_d = elapsed_q + 1'b1;
				end
				if (armed_q) begin
					if (left_q <= IntervalW'(1)) begin
						armed_d = 1'b0;
						left_d  = '0;
						try_fwd = pending_q;
						fwd_value = pending_value_q;
					end else begin
						left_d = left_q - 1'b1;
					end
				end
			end
			CMD_CHANGE: begin
				if (!item_s1.held || !clock_valid_q || elapsed_q >= min_interval_q) begin
					try_fwd = 1'b1;
				end else begin
					pending_we = 1'b1;
					pending_d  = 1'b1;
					armed_d    = 1'b1;
					left_d     = min_interval_q - elapsed_q;
				end
			end
			CMD_PRESS: begin
				clock_valid_d = 1'b0;
			end
			default: begin
				try_fwd = 1'b1;
			end
		endcase

		res_d = '0;
		// Any forward attempt drops the pending value, even if it is then suppressed.
		if (try_fwd) begin
			pending_d = 1'b0;
			armed_d   = 1'b0;
			left_d    = '0;
			if (fwd_value != last_sent_q) begin
				last_sent_d     = fwd_value;
				clock_valid_d   = 1'b1;
				elapsed_d       = '0;
				res_d.forwarded = 1'b1;
				res_d.out_value = fwd_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= IntervalReset;
			last_sent_q    <= '0;
			clock_valid_q  <= 1'b0;
			elapsed_q      <= '0;
			pending_q      <= 1'b0;
			armed_q        <= 1'b0;
			left_q         <= '0;
		end else begin
			if (cfg_we) begin
				min_interval_q <= cfg_wdata;
			end
			if (fire) begin
				last_sent_q   <= last_sent_d;
				clock_valid_q <= clock_valid_d;
				elapsed_q     <= elapsed_d;
				pending_q     <= pending_d;
				armed_q       <= armed_d;
				left_q        <= left_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pending_we) begin
			pending_value_q <= item_s1.new_value;
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign status.clock_valid = clock_valid_q;
	assign status.pending     = pending_q;
	assign status.armed       = armed_q;
	assign status.left_zero   = (left_q == '0);

endmodule

// ----- hw/rtl/value_change_throttle.sv -----
`timescale 1ns / 1ps

// Channel   Direction  tdata                              tuser
// s_*       in         [15:0] new_value, [16] held        [1:0] command
// m_*       out        [15:0] out_value                   [0] forwarded
// cfg_*     in         [15:0] min_interval                -
//
// One event is taken every cycle unless a stall on m_tready holds the result; its
// result is loaded into the result register when the event in the input register fires.
// The state registers are updated in the same cycle as the result register.
// A stall on m_tready holds the result and the input register; s_tready drops
// only once both are full.
// arst_n clears the control state and sets min_interval to 100.

module value_change_throttle
	import vct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,  // [15:0] new_value, [16] held, zero pad
	input  logic [CmdW-1:0]      s_tuser,  // [1:0] command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [ValueW-1:0]    m_tdata,  // [15:0] out_value
	output logic [0:0]           m_tuser,  // [0] forwarded
	input  logic                 cfg_we,
	input  logic [IntervalW-1:0] cfg_wdata
);

	item_t   item_in, item_s1;
	logic    valid_s1, load, fire;
	result_t res_s2;
	status_t status;

	assign item_in.command   = s_tuser;
	assign item_in.new_value = s_tdata[ValueW-1:0];
	assign item_in.held      = s_tdata[ValueW];

	// The event in the input register moves on whenever the result slot is free.
	assign fire     = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign load     = s_tvalid && s_tready;

	vct_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.drain    (fire),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	vct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_s2    (res_s2),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata    = res_s2.out_value;
	assign m_tuser[0] = res_s2.forwarded;

`ifndef NO_ASSERTIONS
	a_armed_iff_pending: assert property (@(posedge clk) disable iff (!arst_n)
		status.armed == status.pending)
		else $error("trailing timer and pending value disagree");

	a_armed_left: assert property (@(posedge clk) disable iff (!arst_n)
		status.armed |-> !status.left_zero)
		else $error("armed timer with nothing left to count");

	a_fwd_starts_clock: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) && m_tuser[0] |-> status.clock_valid)
		else $error("forwarded beat without a running interval clock");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("non-forwarded beat carries a value");
`endif

endmodule

// ----- sim/tb_value_change_throttle.sv -----
`timescale 1ns / 1ps

module tb_value_change_throttle;
	import vct_pkg::*;

	localparam int CycleLimit = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;  // [15:0] new_value, [16] held, zero pad
	logic [CmdW-1:0]      s_tuser = '0;  // [1:0] command
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [ValueW-1:0]    m_tdata;       // [15:0] out_value
	logic [0:0]           m_tuser;       // [0] forwarded
	logic                 cfg_we = 1'b0;
	logic [IntervalW-1:0] cfg_wdata = '0;

	value_change_throttle i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted throttle state.
	logic [IntervalW-1:0] thr_interval = IntervalReset;
	logic [ValueW-1:0]    last_fwd     = '0;
	logic                 clk_ok       = 1'b0;
	logic [IntervalW-1:0] tick_count   = '0;
	logic [ValueW-1:0]    held_val     = '0;
	logic                 held_ok      = 1'b0;
	logic                 flush_armed  = 1'b0;
	logic [IntervalW-1:0] flush_left   = '0;

	item_t   event_q[$];
	result_t fwd_expect_q[$];
	int      n_queued = 0;
	int      n_checked = 0;
	int      fail_cnt = 0;
	int      cycles = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	logic    s_fire = 1'b0;

	// Every forward attempt cancels the pending value; equal values are dropped.
	task automatic try_forward(input logic [ValueW-1:0] v, inout result_t r);
		held_ok     = 1'b0;
		flush_armed = 1'b0;
		flush_left  = '0;
		if (v != last_fwd) begin
			last_fwd    = v;
			clk_ok      = 1'b1;
			tick_count  = '0;
			r.forwarded = 1'b1;
			r.out_value = v;
		end
	endtask

	task automatic throttle_step(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] v,
			input logic h, output result_t r);
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (tick_count != TicksMax)
					tick_count = tick_count + 1'b1;
				if (flush_armed) begin
					if (flush_left <= 1) begin
						flush_armed = 1'b0;
						flush_left  = '0;
						if (held_ok)
							try_forward(held_val, r);
					end else begin
						flush_left = flush_left - 1'b1;
					end
				end
			end
			CMD_CHANGE: begin
				if (!h || !clk_ok || tick_count >= thr_interval) begin
					try_forward(v, r);
				end else begin
					held_val    = v;
					held_ok     = 1'b1;
					flush_left  = thr_interval - tick_count;
					flush_armed = 1'b1;
				end
			end
			CMD_PRESS: begin
				clk_ok = 1'b0;
			end
			default: begin
				try_forward(v, r);
			end
		endcase
	endtask

	// Results are checked before the beat taken at the same edge is predicted.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t pred;
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata};
				n_checked <= n_checked + 1;
				if (fwd_expect_q.size() == 0) begin
					$error("unexpected result beat forwarded=%0b out_value=%0d",
						got.forwarded, got.out_value);
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = fwd_expect_q.pop_front();
					if (got.forwarded !== want.forwarded) begin
						$error("forwarded: expected %0b, actual %0b",
							want.forwarded, got.forwarded);
						fail_cnt <= fail_cnt + 1;
					end
					if (got.out_value !== want.out_value) begin
						$error("out_value: expected %0d, actual %0d",
							want.out_value, got.out_value);
						fail_cnt <= fail_cnt + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				throttle_step(s_tuser, s_tdata[15:0], s_tdata[16], pred);
				fwd_expect_q.push_back(pred);
			end
		end
		s_fire <= arst_n && s_tvalid && s_tready;
	end

	// Source and sink both change their outputs on the falling edge.
	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = event_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {7'b0, nxt.held, nxt.new_value};
				s_tuser  <= nxt.command;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_event(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] v,
			input logic h);
		event_q.push_back('{held: h, new_value: v, command: cmd});
		n_queued++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_event(CMD_TICK, 16'($urandom), 1'($urandom));
	endtask

	// Mostly a few values near zero, so that repeats of the last value are common.
	function automatic logic [ValueW-1:0] pick_value();
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		return 16'($urandom_range(4)) - 16'd2;
	endfunction

	task automatic drain();
		wait (n_checked == n_queued);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_interval(input logic [IntervalW-1:0] v);
		@(negedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= v;
		thr_interval = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Press, a burst of changes and ticks, then usually a release; some noise between.
	task automatic random_phase(input logic [IntervalW-1:0] iv, input int n_items,
			input int idle, input int stall);
		int target;
		int span;
		target = n_queued + n_items;
		span = (iv > 10) ? 12 : int'(iv) + 2;
		write_interval(iv);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		while (n_queued < target) begin
			if ($urandom_range(99) < 15) begin
				push_event(2'($urandom), 16'($urandom), 1'($urandom));
			end else begin
				push_event(CMD_PRESS, 16'($urandom), 1'($urandom));
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(3) != 0)
						push_event(CMD_CHANGE, pick_value(), $urandom_range(9) != 0);
					push_ticks($urandom_range(span));
				end
				if ($urandom_range(9) != 0)
					push_event(CMD_RELEASE, pick_value(), 1'($urandom));
			end
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset interval of 100: ignored fields, suppression, invalid clock, cancelling.
		push_event(CMD_TICK, 16'sh7fff, 1'b1);
		push_event(CMD_CHANGE, 16'sh0000, 1'b0);
		push_event(CMD_CHANGE, 16'sh7fff, 1'b1);
		push_event(CMD_CHANGE, 16'sh8000, 1'b1);
		push_event(CMD_TICK, 16'sh0000, 1'b0);
		push_event(CMD_PRESS, 16'shffff, 1'b1);
		push_event(CMD_CHANGE, 16'sh0005, 1'b1);
		push_event(CMD_CHANGE, 16'sh0006, 1'b1);
		push_event(CMD_RELEASE, 16'sh8000, 1'b0);
		push_event(CMD_RELEASE, 16'sh8000, 1'b1);
		push_event(CMD_CHANGE, 16'sh0001, 1'b0);
		drain();

		// Short interval: a trailing flush, a suppressed flush, then an elapsed interval.
		write_interval(16'd2);
		push_event(CMD_CHANGE, 16'sh0002, 1'b1);
		push_ticks(2);
		push_event(CMD_CHANGE, 16'sh0002, 1'b1);
		push_ticks(3);
		push_event(CMD_CHANGE, 16'sh0009, 1'b1);
		push_event(CMD_TICK, 16'sh0000, 1'b0);
		drain();

		// Widest interval: a long trailing timer cancelled by a release.
		write_interval(16'hffff);
		push_event(CMD_RELEASE, 16'sh0064, 1'b0);
		push_event(CMD_CHANGE, 16'sh0003, 1'b1);
		push_event(CMD_RELEASE, 16'sh0065, 1'b0);
		drain();

		// Longer interval: a flush with one tick left, then an elapsed interval.
		write_interval(16'd40);
		push_ticks(39);
		push_event(CMD_CHANGE, 16'sh0008, 1'b1);
		push_event(CMD_TICK, 16'sh0000, 1'b0);
		push_ticks(41);
		push_event(CMD_CHANGE, 16'sh0009, 1'b1);
		drain();

		random_phase(16'd0, 300, 0, 0);
		random_phase(16'($urandom_range(3, 6)), 400, 46, 0);
		random_phase(16'($urandom_range(5, 9)), 400, 0, 46);
		random_phase(16'($urandom_range(1, 10)), 400, 27, 27);

		if (fail_cnt == 0 && fwd_expect_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
